// File: design/rtpd_pkg.sv
// Shared types and constants of the RTP to Annex B depacketizer.
package rtpd_pkg;

    // NAL header fields
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NAL_FNRI_MASK = 8'hE0;

    // NAL unit types with special handling
    localparam logic [4:0] NAL_TYPE_PASS   = 5'd0;
    localparam logic [4:0] NAL_TYPE_STAP_A = 5'd24;
    localparam logic [4:0] NAL_TYPE_STAP_B = 5'd25;
    localparam logic [4:0] NAL_TYPE_MTAP_HI = 5'd27;
    localparam logic [4:0] NAL_TYPE_FU_A   = 5'd28;
    localparam logic [4:0] NAL_TYPE_FU_B   = 5'd29;

    // Byte positions within a packet (saturating)
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_FU_HDR = 2'd1;
    localparam logic [1:0] POS_BODY  = 2'd3;

    // Start code 00 00 01 and the beat index of the payload byte
    localparam logic [7:0] SC_ZERO     = 8'h00;
    localparam logic [7:0] SC_ONE      = 8'h01;
    localparam logic [1:0] IDX_SC_LAST = 2'd2;
    localparam logic [1:0] IDX_DATA    = 2'd3;

    // What one input byte turns into
    typedef struct packed {
        logic       sc;       // start code ahead of the data
        logic       byte_en;  // a data byte goes out
        logic [7:0] data;     // the data byte
        logic       endf;     // caused by the packet's last byte
    } plan_t;

endpackage

// File: design/rtpd_parse.sv
// Input register, per-packet state and decode of one payload byte into an emit plan.
module rtpd_parse
    import rtpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       plan_valid,
    input  logic       plan_ready,
    output plan_t      plan
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic [1:0] pos_reg, pos_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [4:0] type_reg, type_next;
    logic       consume;
    logic       nonempty;
    logic [4:0] t0;
    logic       fu_now, fu_first, agg_first, mtap_now;

    // Decode of the registered byte against the packet state
    always_comb
    begin
        t0        = s1_byte_reg[4:0];
        fu_first  = (t0 == NAL_TYPE_FU_A) || (t0 == NAL_TYPE_FU_B);
        agg_first = (t0 >= NAL_TYPE_STAP_A) && (t0 <= NAL_TYPE_MTAP_HI);
        fu_now    = (type_reg == NAL_TYPE_FU_A) || (type_reg == NAL_TYPE_FU_B);
        mtap_now  = (type_reg >= NAL_TYPE_STAP_B) && (type_reg <= NAL_TYPE_MTAP_HI);
        plan.sc      = 1'b0;
        plan.byte_en = 1'b1;
        plan.data    = s1_byte_reg;
        plan.endf    = s1_last_reg;
        if (pos_reg == POS_FIRST)
        begin
            if (t0 == NAL_TYPE_PASS)
            begin
                plan.byte_en = 1'b1;
            end
            else if (agg_first)
            begin
                plan.sc      = 1'b1;
                plan.byte_en = 1'b0;
            end
            else if (fu_first)
            begin
                plan.byte_en = 1'b0;
            end
            else
            begin
                plan.sc = 1'b1;
            end
        end
        else if (fu_now)
        begin
            if (pos_reg == POS_FU_HDR)
            begin
                plan.sc      = s1_byte_reg[7];
                plan.byte_en = s1_byte_reg[7];
                plan.data    = (hdr_reg & NAL_FNRI_MASK) | (s1_byte_reg & NAL_TYPE_MASK);
            end
        end
        else if (mtap_now)
        begin
            plan.byte_en = (pos_reg == POS_BODY);
        end
        nonempty = plan.sc | plan.byte_en;
    end

    // Handshake: a byte with no output leaves without waiting on the emitter
    assign consume    = s1_valid_reg && (!nonempty || plan_ready);
    assign plan_valid = s1_valid_reg && nonempty;
    assign in_ready   = !s1_valid_reg || consume;

    // Next state of the packet tracker
    always_comb
    begin
        s1_valid_next = in_ready ? in_valid : s1_valid_reg;
        pos_next      = pos_reg;
        hdr_next      = hdr_reg;
        type_next     = type_reg;
        if (consume)
        begin
            if (pos_reg == POS_FIRST)
            begin
                hdr_next  = s1_byte_reg;
                type_next = t0;
            end
            if (s1_last_reg)
            begin
                pos_next = POS_FIRST;
            end
            else if (pos_reg != POS_BODY)
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= POS_FIRST;
            hdr_reg      <= '0;
            type_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pos_reg      <= pos_next;
            hdr_reg      <= hdr_next;
            type_reg     <= type_next;
        end
    end

    // Input data register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

endmodule

// File: design/rtpd_emit.sv
// Result register that plays out a plan as start code beats, a data beat, or both.
module rtpd_emit
    import rtpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       plan_valid,
    output logic       plan_ready,
    input  plan_t      plan,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data,
    output logic       out_sc,
    output logic       out_endf,
    output logic       out_last
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    plan_t      plan_reg;
    logic       load;
    logic       beat_done;

    // Index 0..2 walk the start code, index 3 is the data byte
    assign out_valid = valid_reg;
    assign out_sc    = (idx_reg != IDX_DATA);
    assign out_endf  = plan_reg.endf;
    assign out_last  = (idx_reg == IDX_DATA) || ((idx_reg == IDX_SC_LAST) && !plan_reg.byte_en);
    assign out_data  = (idx_reg == IDX_DATA) ? plan_reg.data :
                       ((idx_reg == IDX_SC_LAST) ? SC_ONE : SC_ZERO);

    assign beat_done  = valid_reg && out_ready;
    assign plan_ready = !valid_reg || (beat_done && out_last);
    assign load       = plan_valid && plan_ready;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = plan.sc ? '0 : IDX_DATA;
        end
        else if (beat_done)
        begin
            if (out_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= IDX_DATA;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan;
        end
    end

endmodule

// File: design/h264_rtp_to_annexb_depacketizer.sv
// Top level of the H.264 RTP payload to Annex B byte stream depacketizer.
//
// Slave stream: one RTP payload byte per beat in s_axis_tdata, s_axis_tlast on
// the packet's last byte. Master stream: one Annex B byte per beat; tuser bit 0
// marks bytes of an inserted 00 00 01 start code, tuser bit 1 marks beats caused
// by a packet's last byte, tlast marks the last beat caused by one input byte.
// The NAL type from each packet's first byte decides which leading bytes are
// dropped and where a start code goes; FU headers are rebuilt on the start bit.
// A byte is held in the input register, then its first output beat is shown
// from the result register. Throughput: one input byte per cycle when it makes
// one output beat and m_axis_tready is high; for a byte with a start code, the
// single result register plays out 00 00 01 and then any data byte in order,
// and the next byte waits in the input register until those beats are done.
// Bytes that make no output leave without waiting on the result register.
// Reset clears both stages and the packet tracker; the next byte starts a
// packet. When the receiver stalls, the result register holds its beat, the
// input register fills, and s_axis_tready falls until beats drain.
module h264_rtp_to_annexb_depacketizer
    import rtpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  logic       s_axis_tlast,   // packet_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] is_start_code, [1] from_packet_end
    output logic       m_axis_tlast    // run_last
);

    plan_t plan;
    logic  plan_valid;
    logic  plan_ready;

    rtpd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .plan_valid (plan_valid),
        .plan_ready (plan_ready),
        .plan       (plan)
    );

    rtpd_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan_ready (plan_ready),
        .plan       (plan),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_sc     (m_axis_tuser[0]),
        .out_endf   (m_axis_tuser[1]),
        .out_last   (m_axis_tlast)
    );

    // A start code beat ends its run only as the 01 of a start code with no data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast) |-> (m_axis_tdata == SC_ONE))
        else $error("start code run ends on a 00 byte");

    // Start code beats carry only 00 or 01
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (m_axis_tdata == SC_ZERO || m_axis_tdata == SC_ONE))
        else $error("bad start code byte");

    // Beats of one run follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a run");

    // The packet end flag is the same on every beat of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tuser[1] == $past(m_axis_tuser[1])))
        else $error("packet end flag changed inside a run");

    // The input stage never takes a byte while the result register stalls full
    assert property (@(posedge clk) disable iff (!rst_n)
        (plan_valid && !plan_ready) |-> !s_axis_tready)
        else $error("input accepted over a stalled plan");

endmodule
